// ===== rtl/zcl_frame_attribute_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Frame attribute parser assertion macros
// Concurrent checks on the clk / rst_n domain, empty for synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ZCL_FRAME_ATTRIBUTE_PARSER_MACROS_SVH
`define ZCL_FRAME_ATTRIBUTE_PARSER_MACROS_SVH

`ifndef SYNTH

// Check cons in the same cycle as ante.
`define ZFAP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zfap check failed");

// Check cons in the cycle after ante.
`define ZFAP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zfap check failed");

`else

`define ZFAP_ASSERT_NOW(lbl, ante, cons)
`define ZFAP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/zfap_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame attribute parser package
// Beat types, parser state, header constants and the data type size table.
// ----------------------------------------------------------------------------
package zfap_pkg;

    // Frame control bits
    localparam logic [7:0] MASK_MAKER   = 8'h04;
    localparam logic [7:0] MASK_CLUSTER = 8'h01;

    // Global command codes
    localparam logic [7:0] CMD_REPORT   = 8'h0A;
    localparam logic [7:0] CMD_CFG_RESP = 8'h07;
    localparam logic [7:0] CMD_DEF_RESP = 8'h0B;

    // Data type codes with a known value size
    localparam logic [7:0] TYPE_UINT_LO = 8'h20;
    localparam logic [7:0] TYPE_UINT_HI = 8'h27;
    localparam logic [7:0] TYPE_INT_LO  = 8'h28;
    localparam logic [7:0] TYPE_INT_HI  = 8'h2F;
    localparam logic [7:0] TYPE_FLOAT   = 8'h39;
    localparam logic [7:0] TYPE_DOUBLE  = 8'h3A;

    // Result kinds
    localparam logic [2:0] KIND_RECORD  = 3'd0;
    localparam logic [2:0] KIND_CLUSTER = 3'd1;
    localparam logic [2:0] KIND_CFG     = 3'd2;
    localparam logic [2:0] KIND_DEFAULT = 3'd3;
    localparam logic [2:0] KIND_UNSUP   = 3'd4;

    // Parser phases
    localparam logic [3:0] PH_FC       = 4'd0;
    localparam logic [3:0] PH_MAKER    = 4'd1;
    localparam logic [3:0] PH_TSN      = 4'd2;
    localparam logic [3:0] PH_CMD      = 4'd3;
    localparam logic [3:0] PH_REC_HDR  = 4'd4;
    localparam logic [3:0] PH_REC_VAL  = 4'd5;
    localparam logic [3:0] PH_CFG      = 4'd6;
    localparam logic [3:0] PH_DEF_CMD  = 4'd7;
    localparam logic [3:0] PH_DEF_STAT = 4'd8;
    localparam logic [3:0] PH_SKIP     = 4'd9;

    localparam int VALUE_BYTES = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } zfap_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  command_code;
        logic [15:0] attribute_id;
        logic [7:0]  data_type;
        logic [3:0]  value_size;
        logic [63:0] value;
        logic [7:0]  status_code;
        logic [7:0]  answered_command;
        logic        truncated;
    } zfap_out_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [2:0]  header_count;
        logic        maker_flag;
        logic        cluster_flag;
        logic [7:0]  held_command;
        logic [15:0] held_attribute;
        logic [7:0]  held_type;
        logic [63:0] value_accum;
        logic [3:0]  value_count;
        logic [7:0]  held_status;
    } zfap_state_t;

    // Value bytes implied by a data type code, zero if unknown.
    function automatic logic [3:0] type_size(input logic [7:0] t);
        logic [3:0] sz;
        begin
            sz = 4'd0;
            if (t >= TYPE_UINT_LO && t <= TYPE_UINT_HI)
            begin
                sz = {1'b0, t[2:0]} + 4'd1;
            end
            else if (t >= TYPE_INT_LO && t <= TYPE_INT_HI)
            begin
                sz = {1'b0, t[2:0]} + 4'd1;
            end
            else if (t == TYPE_FLOAT)
            begin
                sz = 4'd4;
            end
            else if (t == TYPE_DOUBLE)
            begin
                sz = 4'd8;
            end
            return sz;
        end
    endfunction

    // Parser state after reset: expect frame control, clear the rest.
    function automatic zfap_state_t reset_state();
        zfap_state_t s;
        begin
            s       = '0;
            s.phase = PH_FC;
            return s;
        end
    endfunction

endpackage

// ===== rtl/zfap_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input stage
// Holding register for one byte beat; stalls the sender only while full.
// ----------------------------------------------------------------------------
module zfap_in_stage
    import zfap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_stall,
    input  zfap_in_t byte_data,
    input  logic     take,
    output logic     held_valid,
    output zfap_in_t held_beat
);

    logic     valid_reg;
    logic     valid_next;
    zfap_in_t beat_reg;
    logic     accept;

    // Full and not drained this cycle: hold the sender off.
    assign byte_stall = valid_reg && !take;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg <= byte_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

endmodule

// ===== rtl/zfap_step.sv =====
// ----------------------------------------------------------------------------
// Parser step
// Next parser state and the optional result item for one frame byte.
// ----------------------------------------------------------------------------
module zfap_step
    import zfap_pkg::*;
(
    input  zfap_state_t cur,
    input  zfap_in_t    beat,
    output zfap_state_t nxt,
    output logic        emit,
    output zfap_out_t   item
);

    logic [7:0] b;
    logic       last;
    logic [3:0] sz;
    logic [3:0] count_inc;
    logic       is_record;
    logic       trunc;

    assign b    = beat.data_byte;
    assign last = beat.last_byte;

    always_comb
    begin
        nxt       = cur;
        emit      = 1'b0;
        is_record = 1'b0;
        trunc     = 1'b0;
        item      = '0;
        sz        = type_size(cur.held_type);
        count_inc = cur.value_count + 4'd1;

        case (cur.phase)
            PH_FC:
            begin
                nxt.maker_flag   = (b & MASK_MAKER) != 8'h00;
                nxt.cluster_flag = (b & MASK_CLUSTER) != 8'h00;
                nxt.header_count = 3'd0;
                nxt.phase        = ((b & MASK_MAKER) != 8'h00) ? PH_MAKER : PH_TSN;
            end
            PH_MAKER:
            begin
                nxt.header_count = cur.header_count + 3'd1;
                if (nxt.header_count >= 3'd2)
                begin
                    nxt.header_count = 3'd0;
                    nxt.phase        = PH_TSN;
                end
            end
            PH_TSN:
            begin
                nxt.phase = PH_CMD;
            end
            PH_CMD:
            begin
                nxt.held_command = b;
                nxt.header_count = 3'd0;
                if (cur.cluster_flag)
                begin
                    emit      = 1'b1;
                    item.kind = KIND_CLUSTER;
                    nxt.phase = PH_SKIP;
                end
                else if (b == CMD_REPORT)
                begin
                    nxt.phase = PH_REC_HDR;
                end
                else if (b == CMD_CFG_RESP)
                begin
                    nxt.phase      = PH_CFG;
                    emit           = last;
                    item.kind      = KIND_CFG;
                    item.truncated = 1'b1;
                end
                else if (b == CMD_DEF_RESP)
                begin
                    nxt.phase      = PH_DEF_CMD;
                    emit           = last;
                    item.kind      = KIND_DEFAULT;
                    item.truncated = 1'b1;
                end
                else
                begin
                    emit      = 1'b1;
                    item.kind = KIND_UNSUP;
                    nxt.phase = PH_SKIP;
                end
            end
            PH_REC_HDR:
            begin
                if (cur.header_count == 3'd0)
                begin
                    nxt.held_attribute = {8'h00, b};
                    nxt.header_count   = 3'd1;
                end
                else if (cur.header_count == 3'd1)
                begin
                    nxt.held_attribute = {b, cur.held_attribute[7:0]};
                    nxt.header_count   = 3'd2;
                end
                else
                begin
                    nxt.held_type    = b;
                    nxt.header_count = 3'd0;
                    nxt.value_accum  = '0;
                    nxt.value_count  = 4'd0;
                    if (type_size(b) == 4'd0)
                    begin
                        emit      = 1'b1;
                        is_record = 1'b1;
                    end
                    else
                    begin
                        nxt.phase = PH_REC_VAL;
                        emit      = last;
                        is_record = 1'b1;
                        trunc     = 1'b1;
                    end
                end
            end
            PH_REC_VAL:
            begin
                // Merge the byte into its lane of the value.
                for (int i = 0; i < VALUE_BYTES; i++)
                begin
                    if (cur.value_count == 4'(i))
                    begin
                        nxt.value_accum[8*i +: 8] = cur.value_accum[8*i +: 8] | b;
                    end
                end
                nxt.value_count = count_inc;
                is_record       = 1'b1;
                if (count_inc >= sz)
                begin
                    emit             = 1'b1;
                    nxt.header_count = 3'd0;
                    nxt.phase        = PH_REC_HDR;
                end
                else
                begin
                    emit  = last;
                    trunc = 1'b1;
                end
            end
            PH_CFG:
            begin
                emit             = 1'b1;
                item.kind        = KIND_CFG;
                item.status_code = b;
                nxt.phase        = PH_SKIP;
            end
            PH_DEF_CMD:
            begin
                nxt.held_status       = b;
                nxt.phase             = PH_DEF_STAT;
                emit                  = last;
                item.kind             = KIND_DEFAULT;
                item.answered_command = b;
                item.truncated        = 1'b1;
            end
            PH_DEF_STAT:
            begin
                emit                  = 1'b1;
                item.kind             = KIND_DEFAULT;
                item.status_code      = b;
                item.answered_command = cur.held_status;
                nxt.phase             = PH_SKIP;
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        if (is_record)
        begin
            item.kind         = KIND_RECORD;
            item.attribute_id = nxt.held_attribute;
            item.data_type    = nxt.held_type;
            item.value_size   = type_size(nxt.held_type);
            item.value        = nxt.value_accum;
            item.truncated    = trunc;
        end
        item.command_code = nxt.held_command;

        // Frame end: restart at frame control.
        if (last)
        begin
            nxt.phase        = PH_FC;
            nxt.header_count = 3'd0;
            nxt.value_count  = 4'd0;
        end
    end

endmodule

// ===== rtl/zfap_out_stage.sv =====
// ----------------------------------------------------------------------------
// Output stage
// Result register; holds its item while the receiver stalls.
// ----------------------------------------------------------------------------
module zfap_out_stage
    import zfap_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  logic      emit,
    input  zfap_out_t item_in,
    output logic      room,
    output logic      item_valid,
    input  logic      item_stall,
    output zfap_out_t item_data
);

    logic      valid_reg;
    logic      valid_next;
    zfap_out_t item_reg;

    // Empty, or the held item leaves at this edge.
    assign room = !valid_reg || !item_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = emit;
        end
        else if (valid_reg && !item_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && emit)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = item_reg;

endmodule

// ===== rtl/zcl_frame_attribute_parser.sv =====
// ----------------------------------------------------------------------------
// Cluster-library frame attribute parser
// Splits a byte stream of frames into records, responses and command flags.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid / byte_stall / byte_data) carries one frame
//   byte per beat; byte_data.last_byte marks the final byte of a frame and the
//   next beat opens a new frame. The item channel (item_valid / item_stall /
//   item_data) returns zero or one result per byte: an attribute record, a
//   cluster-specific or unsupported command flag, or a configure / default
//   response status, with truncated set when the frame ended early.
//   Path: an accepted byte is held in the input register, then its result in
//   the result register. Throughput: one byte per cycle unless the receiver
//   stalls, set by the single parser step between the two registers.
//   Reset clears both stage valid bits and returns the parser to expecting
//   frame control. While the receiver stalls, the held result stays put, the
//   parser holds, and byte_stall rises once the input register is full; one
//   more beat is absorbed before the sender is held off.
// ----------------------------------------------------------------------------
`include "zcl_frame_attribute_parser_macros.svh"

module zcl_frame_attribute_parser
    import zfap_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  zfap_in_t  byte_data,
    output logic      item_valid,
    input  logic      item_stall,
    output zfap_out_t item_data
);

    logic        held_valid;
    zfap_in_t    held_beat;
    logic        room;
    logic        take;
    zfap_state_t state_reg;
    zfap_state_t state_next;
    logic        emit;
    zfap_out_t   step_item;

    // Advance the parser when a byte is held and the result register has room.
    assign take = held_valid && room;

    zfap_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .take       (take),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    zfap_step u_step (
        .cur  (state_reg),
        .beat (held_beat),
        .nxt  (state_next),
        .emit (emit),
        .item (step_item)
    );

    // Parser state: update only on a taken byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= reset_state();
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

    zfap_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .emit       (emit),
        .item_in    (step_item),
        .room       (room),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data)
    );

    // A frame-ending byte always leaves the parser expecting frame control.
    `ZFAP_ASSERT_NEXT(a_frame_restart, take && held_beat.last_byte, state_reg.phase == PH_FC)

    // Only attribute records carry record fields.
    `ZFAP_ASSERT_NOW(a_record_fields, item_valid && item_data.kind != KIND_RECORD, item_data.attribute_id == 16'h0000 && item_data.value == 64'h0 && item_data.value_size == 4'd0)

    // A record never claims more than eight value bytes.
    `ZFAP_ASSERT_NOW(a_size_range, item_valid && item_data.kind == KIND_RECORD, item_data.value_size <= 4'd8)

    // A held byte that is not processed stays held.
    `ZFAP_ASSERT_NEXT(a_held_kept, held_valid && !take, held_valid)

endmodule
